// File: design/fifo_with_indexed_removal_defines.svh
`ifndef FIFO_WITH_INDEXED_REMOVAL_DEFINES_SVH
`define FIFO_WITH_INDEXED_REMOVAL_DEFINES_SVH

// Same-cycle check: when cond holds, prop must hold on the same edge.
`define FWIR_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle check: when cond holds, prop must hold on the following edge.
`define FWIR_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: design/fwir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwir_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int HANDLE_BITS_DEFAULT = 16;

   localparam int MODE_W   = 3;
   localparam int ITEM_W   = 16;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 3'd0,
      MODE_POP    = 3'd1,
      MODE_CLEAR  = 3'd2,
      MODE_REMOVE = 3'd3,
      MODE_READ   = 3'd4
   } fwir_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FETCH,
      ST_SHIFT,
      ST_RESULT
   } fwir_state_type;

   typedef struct packed {
      logic               ignored;
      logic               queue_empty;
      logic [COUNT_W-1:0] entry_count;
      logic [ITEM_W-1:0]  item_out;
      logic               item_valid;
   } fwir_result_type;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(fwir_result_type);

endpackage

`default_nettype wire

// File: design/fwir_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fwir_ram #(
   parameter int WIDTH = fwir_pkg::HANDLE_BITS_DEFAULT,
   parameter int DEPTH = fwir_pkg::DEPTH_DEFAULT,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/fwir_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module fwir_seq #(
   parameter int DEPTH       = fwir_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = fwir_pkg::HANDLE_BITS_DEFAULT,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CntW  = $clog2(DEPTH + 1),
   localparam int CmpW  = (CntW > fwir_pkg::POS_W) ? CntW : fwir_pkg::POS_W
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [fwir_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [fwir_pkg::ITEM_W-1:0]      req_item_id,
   input  wire logic [fwir_pkg::POS_W-1:0]       req_position,
   input  wire logic                             out_free,
   output logic                                  res_valid,
   output fwir_pkg::fwir_result_type             res,
   output logic                                  ram_wr_en,
   output logic      [AddrW-1:0]                 ram_wr_addr,
   output logic      [HANDLE_BITS-1:0]           ram_wr_data,
   output logic                                  ram_rd_en,
   output logic      [AddrW-1:0]                 ram_rd_addr,
   input  wire logic [HANDLE_BITS-1:0]           ram_rd_data
);

   localparam int ItemW  = fwir_pkg::ITEM_W;
   localparam int CountW = fwir_pkg::COUNT_W;

   fwir_pkg::fwir_state_type state_ff, state_in;
   fwir_pkg::fwir_mode_type  mode_ff, mode_in;
   logic [ItemW-1:0]         item_ff, item_in;
   logic [fwir_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [CntW-1:0]          occ_ff, occ_in;
   logic [AddrW-1:0]         cursor_ff, cursor_in;
   logic                     pend_ff, pend_in;
   logic [HANDLE_BITS-1:0]   value_ff, value_in;
   logic                     valid_ff, valid_in;
   logic                     ign_ff, ign_in;

   logic [ItemW+HANDLE_BITS-1:0] item_wide;
   logic [ItemW+HANDLE_BITS-1:0] value_wide;
   logic [CntW+CountW-1:0]       count_wide;
   logic [HANDLE_BITS-1:0]       item_handle;
   logic [CntW-1:0]              next_idx;
   logic                         more;
   logic                         pos_ok;
   logic                         occ_zero;
   logic                         full;

   assign item_wide   = {{HANDLE_BITS{1'b0}}, item_ff};
   assign item_handle = item_wide[HANDLE_BITS-1:0];
   assign value_wide  = {{ItemW{1'b0}}, value_ff};
   assign count_wide  = {{CountW{1'b0}}, occ_ff};
   assign next_idx    = CntW'(cursor_ff) + CntW'(1);
   assign more        = next_idx < occ_ff;
   assign pos_ok      = CmpW'(pos_ff) < CmpW'(occ_ff);
   assign occ_zero    = occ_ff == '0;
   assign full        = occ_ff == CntW'(DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwir_pkg::ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
      mode_ff   <= mode_in;
      item_ff   <= item_in;
      pos_ff    <= pos_in;
      cursor_ff <= cursor_in;
      pend_ff   <= pend_in;
      value_ff  <= value_in;
      valid_ff  <= valid_in;
      ign_ff    <= ign_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fwir_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fwir_pkg::ST_DECIDE;
            end
         end
         fwir_pkg::ST_DECIDE: begin
            case (mode_ff)
               fwir_pkg::MODE_POP:    state_in = occ_zero ? fwir_pkg::ST_RESULT
                                                          : fwir_pkg::ST_FETCH;
               fwir_pkg::MODE_REMOVE: state_in = pos_ok ? fwir_pkg::ST_SHIFT
                                                        : fwir_pkg::ST_RESULT;
               fwir_pkg::MODE_READ:   state_in = pos_ok ? fwir_pkg::ST_FETCH
                                                        : fwir_pkg::ST_RESULT;
               default:               state_in = fwir_pkg::ST_RESULT;
            endcase
         end
         fwir_pkg::ST_FETCH: begin
            state_in = (mode_ff == fwir_pkg::MODE_POP) ? fwir_pkg::ST_SHIFT
                                                       : fwir_pkg::ST_RESULT;
         end
         fwir_pkg::ST_SHIFT: begin
            if (!more) begin
               state_in = fwir_pkg::ST_RESULT;
            end
         end
         fwir_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = fwir_pkg::ST_IDLE;
            end
         end
         default: state_in = fwir_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AddrW'(occ_ff);
      ram_wr_data = item_handle;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AddrW'(next_idx);
      case (state_ff)
         fwir_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         fwir_pkg::ST_DECIDE: begin
            case (mode_ff)
               fwir_pkg::MODE_APPEND: begin
                  ram_wr_en = (item_handle != '0) && !full;
               end
               fwir_pkg::MODE_POP: begin
                  ram_rd_en   = !occ_zero;
                  ram_rd_addr = '0;
               end
               fwir_pkg::MODE_READ: begin
                  ram_rd_en   = pos_ok;
                  ram_rd_addr = AddrW'(pos_ff);
               end
               default: begin
               end
            endcase
         end
         fwir_pkg::ST_SHIFT: begin
            ram_rd_en   = more;
            ram_wr_en   = pend_ff;
            ram_wr_addr = cursor_ff - AddrW'(1);
            ram_wr_data = ram_rd_data;
         end
         fwir_pkg::ST_RESULT: begin
            res_valid = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      item_in   = item_ff;
      pos_in    = pos_ff;
      occ_in    = occ_ff;
      cursor_in = cursor_ff;
      pend_in   = pend_ff;
      value_in  = value_ff;
      valid_in  = valid_ff;
      ign_in    = ign_ff;
      case (state_ff)
         fwir_pkg::ST_IDLE: begin
            mode_in = fwir_pkg::fwir_mode_type'(req_mode);
            item_in = req_item_id;
            pos_in  = req_position;
         end
         fwir_pkg::ST_DECIDE: begin
            value_in  = '0;
            valid_in  = 1'b0;
            pend_in   = 1'b0;
            cursor_in = AddrW'(pos_ff);
            case (mode_ff)
               fwir_pkg::MODE_APPEND: begin
                  ign_in = (item_handle == '0) || full;
                  if (!ign_in) begin
                     occ_in = occ_ff + CntW'(1);
                  end
               end
               fwir_pkg::MODE_POP: begin
                  ign_in    = occ_zero;
                  cursor_in = '0;
               end
               fwir_pkg::MODE_CLEAR: begin
                  ign_in = 1'b0;
                  occ_in = '0;
               end
               fwir_pkg::MODE_REMOVE: ign_in = !pos_ok;
               fwir_pkg::MODE_READ:   ign_in = !pos_ok;
               default:               ign_in = 1'b1;
            endcase
         end
         fwir_pkg::ST_FETCH: begin
            value_in = ram_rd_data;
            valid_in = 1'b1;
         end
         fwir_pkg::ST_SHIFT: begin
            pend_in = more;
            if (more) begin
               cursor_in = AddrW'(next_idx);
            end else begin
               occ_in = occ_ff - CntW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res.item_valid  = valid_ff;
      res.item_out    = value_wide[ItemW-1:0];
      res.entry_count = count_wide[CountW-1:0];
      res.queue_empty = occ_zero;
      res.ignored     = ign_ff;
   end

endmodule

`default_nettype wire

// File: design/fifo_with_indexed_removal.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered queue of item handles with append, pop front, clear, remove at a
// position and read at a position; every request beat yields one response beat
// that carries the entry count and an ignored flag. Requests are handled one at
// a time, and the single entry RAM, with one write and one registered read port,
// moves one entry per cycle while a removal closes the gap. An append, a clear
// or an ignored request passes through the decide and result states, a read
// adds a fetch, a remove at position p shifts the entries behind p, and a pop
// fetches the head and then shifts all other entries. A finished response waits
// in the output register while the next request is accepted; the block stalls
// only when a new response is ready and the previous one has not been taken.
module fifo_with_indexed_removal #(
   parameter int DEPTH       = fwir_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = fwir_pkg::HANDLE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // mode [2:0], item_id [18:3], position [24:19], zero padding above
   input  wire logic [fwir_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // item_valid [0], item_out [16:1], entry_count [23:17], queue_empty [24],
   // ignored [25], zero padding above
   output logic      [fwir_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ModeW = fwir_pkg::MODE_W;
   localparam int ItemW = fwir_pkg::ITEM_W;
   localparam int PosW  = fwir_pkg::POS_W;

   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [fwir_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                      out_free;
   logic                      res_valid;
   fwir_pkg::fwir_result_type res;
   logic                      ram_wr_en;
   logic [AddrW-1:0]          ram_wr_addr;
   logic [HANDLE_BITS-1:0]    ram_wr_data;
   logic                      ram_rd_en;
   logic [AddrW-1:0]          ram_rd_addr;
   logic [HANDLE_BITS-1:0]    ram_rd_data;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   fwir_seq #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_mode     (req_tdata[ModeW-1:0]),
      .req_item_id  (req_tdata[ModeW+ItemW-1:ModeW]),
      .req_position (req_tdata[ModeW+ItemW+PosW-1:ModeW+ItemW]),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   fwir_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_valid) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{fwir_pkg::RSP_PAD_W{1'b0}}, res};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// File: design/fwir_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_with_indexed_removal_defines.svh"

module fwir_chk (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [fwir_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response beat keeps its payload.
   `FWIR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response beat changed while stalled")

   // The queue works on one request at a time.
   `FWIR_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "request taken while another is in progress")

   `FWIR_ASSERT_NOW(a_empty_count, rsp_tvalid && rsp_tdata[24], rsp_tdata[23:17] == 7'd0, "empty queue reported with nonzero count")

   `FWIR_ASSERT_NOW(a_item_not_ignored, rsp_tvalid && rsp_tdata[0], !rsp_tdata[25], "returned item on an ignored request")

   `FWIR_ASSERT_NOW(a_no_item_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[16:1] == 16'd0, "item_out nonzero without item_valid")

endmodule

bind fifo_with_indexed_removal fwir_chk u_fwir_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fwir_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_W'(MODE_READ) + 1'b1;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;
   localparam int RANDOM_BATCH = 425;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [ITEM_W-1:0] item_id;
      logic [MODE_W-1:0] mode;
   } queue_request_type;

   typedef enum int {EPISODE_FILL, EPISODE_GROW, EPISODE_SHRINK, EPISODE_MIXED} episode_kind_type;
   typedef enum int {SINK_ALWAYS, SINK_MOSTLY, SINK_RARELY, SINK_TOGGLE} sink_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   queue_request_type pending_requests[$];
   fwir_result_type   expected_results[$];
   logic [ITEM_W-1:0] shadow_entries[DEPTH_DEFAULT];
   int shadow_count = 0;

   int requests_sent = 0;
   int responses_checked = 0;
   int mismatch_count = 0;
   logic req_beat_taken = 1'b0;
   queue_request_type seen_request;
   fwir_result_type   got_result;
   fwir_result_type   want_result;

   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int next_hold_at = 120;
   int style_left = 0;
   sink_style_type sink_style = SINK_ALWAYS;

   fifo_with_indexed_removal dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic void close_gap(input int position);
      for (int i = position; i + 1 < shadow_count; i++) begin
         shadow_entries[i] = shadow_entries[i + 1];
      end
   endfunction

   function automatic fwir_result_type predict_queue_result(input queue_request_type r);
      fwir_result_type res;
      res = '0;
      case (r.mode)
         MODE_APPEND: begin
            if (r.item_id == '0 || shadow_count >= DEPTH_DEFAULT) begin
               res.ignored = 1'b1;
            end else begin
               shadow_entries[shadow_count] = r.item_id;
               shadow_count++;
            end
         end
         MODE_POP: begin
            if (shadow_count == 0) begin
               res.ignored = 1'b1;
            end else begin
               res.item_valid = 1'b1;
               res.item_out = shadow_entries[0];
               close_gap(0);
               shadow_count--;
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         MODE_REMOVE: begin
            if (int'(r.position) >= shadow_count) begin
               res.ignored = 1'b1;
            end else begin
               close_gap(int'(r.position));
               shadow_count--;
            end
         end
         MODE_READ: begin
            if (int'(r.position) >= shadow_count) begin
               res.ignored = 1'b1;
            end else begin
               res.item_valid = 1'b1;
               res.item_out = shadow_entries[r.position];
            end
         end
         default: begin
            res.ignored = 1'b1;
         end
      endcase
      res.entry_count = COUNT_W'(shadow_count);
      res.queue_empty = (shadow_count == 0);
      return res;
   endfunction

   task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [ITEM_W-1:0] item_id,
                                input logic [POS_W-1:0] position);
      queue_request_type r;
      r.mode = mode;
      r.item_id = item_id;
      r.position = position;
      pending_requests = {pending_requests, r};
      requests_sent++;
   endtask

   task automatic wait_until_quiet();
      do begin
         @(negedge clock);
      end while (responses_checked != requests_sent);
   endtask

   // Each result beat is checked before the request beat of the same edge is predicted.
   always @(posedge clock) begin
      req_beat_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_result = fwir_result_type'(rsp_tdata[$bits(fwir_result_type)-1:0]);
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                         responses_checked));
            end else begin
               want_result = expected_results.pop_front();
               if (got_result.item_valid !== want_result.item_valid)
                  report_mismatch($sformatf("beat %0d item_valid %0b, expected %0b",
                     responses_checked, got_result.item_valid, want_result.item_valid));
               if (got_result.item_out !== want_result.item_out)
                  report_mismatch($sformatf("beat %0d item_out %h, expected %h",
                     responses_checked, got_result.item_out, want_result.item_out));
               if (got_result.entry_count !== want_result.entry_count)
                  report_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
                     responses_checked, got_result.entry_count, want_result.entry_count));
               if (got_result.queue_empty !== want_result.queue_empty)
                  report_mismatch($sformatf("beat %0d queue_empty %0b, expected %0b",
                     responses_checked, got_result.queue_empty, want_result.queue_empty));
               if (got_result.ignored !== want_result.ignored)
                  report_mismatch($sformatf("beat %0d ignored %0b, expected %0b",
                     responses_checked, got_result.ignored, want_result.ignored));
            end
            responses_checked++;
         end
         if (req_tvalid && req_tready) begin
            seen_request = queue_request_type'(req_tdata[$bits(queue_request_type)-1:0]);
            expected_results = {expected_results, predict_queue_result(seen_request)};
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         if (gap_left > 0 || pending_requests.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tdata <= REQ_TDATA_W'(pending_requests.pop_front());
            req_tvalid <= 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(40, 1);
            burst_left--;
            if (burst_left == 0) begin
               case ($urandom_range(3, 0))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(30, 10);
                  default: gap_left = $urandom_range(6, 1);
               endcase
            end
         end
      end
   end

   // The sink holds off for a long stretch now and then so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (responses_checked >= next_hold_at) begin
         next_hold_at = next_hold_at + 350;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            sink_style = sink_style_type'($urandom_range(3, 0));
            style_left = $urandom_range(300, 50);
         end
         style_left--;
         case (sink_style)
            SINK_ALWAYS: rsp_tready <= 1'b1;
            SINK_MOSTLY: rsp_tready <= ($urandom_range(3, 0) != 0);
            SINK_RARELY: rsp_tready <= ($urandom_range(3, 0) == 0);
            default:     rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      episode_kind_type kind;
      int episode_left;
      int planned_count;
      int generated;
      int p_append, p_pop, p_remove, p_read, p_clear;
      int pick;
      logic [MODE_W-1:0] mode;
      logic [ITEM_W-1:0] item_id;
      logic [POS_W-1:0] position;

      queue_request(MODE_CLEAR, 16'h0000, 6'd0);
      queue_request(MODE_POP, 16'h0000, 6'd0);
      queue_request(MODE_REMOVE, 16'hFFFF, 6'd0);
      queue_request(MODE_READ, 16'h0000, 6'd63);
      queue_request(MODE_APPEND, 16'h0000, 6'd63);
      queue_request(MODE_APPEND, 16'hFFFF, 6'd0);
      queue_request(MODE_APPEND, 16'h0001, 6'd0);
      queue_request(MODE_APPEND, 16'h8000, 6'd0);
      queue_request(MODE_APPEND, 16'h5A5A, 6'd0);
      queue_request(MODE_READ, 16'h0000, 6'd0);
      queue_request(MODE_READ, 16'h0000, 6'd3);
      queue_request(MODE_READ, 16'h0000, 6'd4);
      queue_request(MODE_REMOVE, 16'h0000, 6'd1);
      queue_request(MODE_READ, 16'h0000, 6'd1);
      queue_request(MODE_REMOVE, 16'h0000, 6'd2);
      queue_request(MODE_REMOVE, 16'h0000, 6'd2);
      for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) begin
         queue_request(MODE_W'(m), ITEM_W'($urandom), POS_W'($urandom));
      end
      queue_request(MODE_POP, 16'h0000, 6'd0);
      queue_request(MODE_POP, 16'h0000, 6'd0);
      queue_request(MODE_POP, 16'h0000, 6'd0);
      queue_request(MODE_APPEND, 16'h1234, 6'd0);
      queue_request(MODE_CLEAR, 16'hFFFF, 6'd63);
      queue_request(MODE_READ, 16'h0000, 6'd0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_until_quiet();

      planned_count = 0;
      episode_left = 0;
      kind = EPISODE_FILL;
      for (generated = 0; generated < 2 * RANDOM_BATCH; generated++) begin
         if (generated == RANDOM_BATCH) wait_until_quiet();
         if (episode_left == 0) begin
            kind = episode_kind_type'($urandom_range(3, 0));
            episode_left = (kind == EPISODE_SHRINK) ? $urandom_range(80, 20)
                                                    : $urandom_range(150, 40);
         end
         episode_left--;
         case (kind)
            EPISODE_FILL: begin
               p_append = 92; p_pop = 0; p_remove = 2; p_read = 4; p_clear = 0;
            end
            EPISODE_GROW: begin
               p_append = 70; p_pop = 6; p_remove = 8; p_read = 13; p_clear = 1;
            end
            EPISODE_SHRINK: begin
               p_append = 15; p_pop = 35; p_remove = 30; p_read = 16; p_clear = 2;
            end
            default: begin
               p_append = 35; p_pop = 20; p_remove = 20; p_read = 20; p_clear = 3;
            end
         endcase
         pick = $urandom_range(99, 0);
         if (pick < p_append) mode = MODE_APPEND;
         else if (pick < p_append + p_pop) mode = MODE_POP;
         else if (pick < p_append + p_pop + p_remove) mode = MODE_REMOVE;
         else if (pick < p_append + p_pop + p_remove + p_read) mode = MODE_READ;
         else if (pick < p_append + p_pop + p_remove + p_read + p_clear) mode = MODE_CLEAR;
         else mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));

         pick = $urandom_range(99, 0);
         if (pick < 4) item_id = '0;
         else if (pick < 8) item_id = '1;
         else item_id = ITEM_W'($urandom_range(16'hFFFF, 1));

         pick = $urandom_range(99, 0);
         if (planned_count > 0 && pick < 12) position = POS_W'(planned_count - 1);
         else if (planned_count > 0 && pick < 80)
            position = POS_W'($urandom_range(planned_count - 1, 0));
         else position = POS_W'($urandom);

         case (mode)
            MODE_APPEND: if (item_id != '0 && planned_count < DEPTH_DEFAULT) planned_count++;
            MODE_POP:    if (planned_count > 0) planned_count--;
            MODE_CLEAR:  planned_count = 0;
            MODE_REMOVE: if (int'(position) < planned_count) planned_count--;
            default: ;
         endcase
         queue_request(mode, item_id, position);
      end

      wait_until_quiet();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/fwir_pkg.sv
design/fwir_ram.sv
design/fwir_seq.sv
design/fifo_with_indexed_removal.sv
design/fwir_chk.sv
tb/sv/testbench.sv
